// File: rtl/core/temp_reading_to_ascii_report_unit_assert.svh
// Assertion macros for the temperature report unit.
// Define ASSERT_OFF to compile the checks out.
`ifndef TEMP_READING_TO_ASCII_REPORT_UNIT_ASSERT_SVH
`define TEMP_READING_TO_ASCII_REPORT_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// Check that holds outside reset.
`define TR2A_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("tr2a check failed");

// Check that also holds through reset.
`define TR2A_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("tr2a reset check failed");

`else

`define TR2A_ASSERT(lbl, clk, rst_n, prop)
`define TR2A_ASSERT_RST(lbl, clk, prop)

`endif

`endif

// File: rtl/core/tr2a_pkg.sv
`default_nettype none

package tr2a_pkg;

    // ASCII codes used in the report, in the 6-bit field width.
    localparam logic [5:0] CHAR_PLUS  = 6'd43;
    localparam logic [5:0] CHAR_MINUS = 6'd45;
    localparam logic [5:0] CHAR_POINT = 6'd46;
    localparam logic [5:0] CHAR_ZERO  = 6'd48;

    // Field widths.
    localparam int RAW_W   = 16;
    localparam int MAG_W   = 14;
    localparam int TENTH_W = 12;   // rounded magnitude in tenths, at most 2560
    localparam int CNT_W   = 16;
    localparam int PROD_W  = 24;   // tenths times a reciprocal constant

    // Reciprocal constants: q = (t * RECIP) >> SHIFT is exact for t <= 2560.
    localparam logic [11:0] RECIP_10   = 12'd3277;
    localparam logic [11:0] RECIP_100  = 12'd1311;
    localparam logic [11:0] RECIP_1000 = 12'd1049;

    // Rounding remainder that marks an exact half.
    localparam logic [3:0] REM_HALF = 4'd8;

    typedef struct packed {
        logic               negative;
        logic [TENTH_W-1:0] tenths;
        logic [CNT_W-1:0]   count;
    } t_rounded;

    typedef struct packed {
        logic               negative;
        logic [TENTH_W-1:0] tenths;
        logic [8:0]         q_ten;
        logic [4:0]         q_hun;
        logic [1:0]         q_thou;
        logic [CNT_W-1:0]   count;
    } t_quotients;

    // Decimal digit to ASCII.
    function automatic logic [5:0] to_ascii(input logic [3:0] digit);
        return CHAR_ZERO + {2'b00, digit};
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/tr2a_in_if.sv
`default_nettype none

interface tr2a_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] raw_reading;

    modport source (output valid, output raw_reading, input ready);
    modport sink (input valid, input raw_reading, output ready);
endinterface

`default_nettype wire

// File: rtl/core/tr2a_out_if.sv
`default_nettype none

interface tr2a_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] sign_char;
    logic [5:0] hundreds_char;
    logic [5:0] tens_char;
    logic [5:0] units_char;
    logic [5:0] point_char;
    logic [5:0] tenths_char;
    logic [7:0] count_high;
    logic [7:0] count_low;

    modport source (
        output valid, input ready,
        output sign_char, output hundreds_char, output tens_char, output units_char,
        output point_char, output tenths_char, output count_high, output count_low
    );
    modport sink (
        input valid, output ready,
        input sign_char, input hundreds_char, input tens_char, input units_char,
        input point_char, input tenths_char, input count_high, input count_low
    );
endinterface

`default_nettype wire

// File: rtl/core/temp_reading_to_ascii_report_unit.sv
// Channel    Dir  Payload                                          Width
// i_reading  in   raw_reading                                      16
// o_report   out  sign, hundreds, tens, units, point, tenths chars 6 each
//                 count_high, count_low                            8 each
//
// Three register stages: round to tenths, reciprocal divides, ASCII digits.
// One word is taken per cycle while o_report is not stalled; each word
// passes the round, divide and result registers on its way to o_report.
// Each stage holds its word while the next one is stalled.
// Synchronous active-low reset empties the stages and clears the count.
`default_nettype none

`include "temp_reading_to_ascii_report_unit_assert.svh"

module temp_reading_to_ascii_report_unit
    import tr2a_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tr2a_in_if.sink    i_reading,
    tr2a_out_if.source o_report
);

    logic       w_s1_valid;
    logic       w_s1_ready;
    t_rounded   w_s1_data;
    logic       w_s2_valid;
    logic       w_s2_ready;
    t_quotients w_s2_data;

    // Sign, magnitude and rounding; holds the sample count.
    tr2a_round u_round (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_reading (i_reading),
        .o_valid   (w_s1_valid),
        .i_ready   (w_s1_ready),
        .o_data    (w_s1_data)
    );

    // Decimal quotients of the rounded tenths.
    tr2a_divide u_divide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s1_valid),
        .o_ready (w_s1_ready),
        .i_data  (w_s1_data),
        .o_valid (w_s2_valid),
        .i_ready (w_s2_ready),
        .o_data  (w_s2_data)
    );

    // Digit characters and the result register.
    tr2a_ascii u_ascii (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_s2_valid),
        .o_ready  (w_s2_ready),
        .i_data   (w_s2_data),
        .o_report (o_report)
    );

    // Checks on the report stream.
    logic        w_out_take;
    logic [15:0] w_out_count;
    assign w_out_take  = o_report.valid && o_report.ready;
    assign w_out_count = {o_report.count_high, o_report.count_low};

    `TR2A_ASSERT_RST(a_reset_empties, i_clk, !i_rst_n |=> !o_report.valid)
    `TR2A_ASSERT(a_point, i_clk, i_rst_n, o_report.valid |-> o_report.point_char == CHAR_POINT)
    `TR2A_ASSERT(a_hundreds_range, i_clk, i_rst_n,
        o_report.valid |-> o_report.hundreds_char <= 6'd50)
    `TR2A_ASSERT(a_count_steps, i_clk, i_rst_n,
        w_out_take |=> (!w_out_take || (w_out_count == $past(w_out_count) + 16'd1)))

endmodule

`default_nettype wire

// File: rtl/core/tr2a_round.sv
`default_nettype none

module tr2a_round
    import tr2a_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    tr2a_in_if.sink       i_reading,
    output logic          o_valid,
    input  wire logic     i_ready,
    output t_rounded      o_data
);

    logic               r_valid;
    t_rounded           r_data;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               w_take;
    logic               w_neg;
    logic [MAG_W-1:0]   w_field;
    logic [MAG_W-1:0]   w_mag;
    logic [15:0]        w_prod;
    logic [TENTH_W-1:0] w_trunc;
    logic [3:0]         w_rem;
    logic               w_up;

    // The stage takes a new word when it is empty or its word leaves now.
    assign i_reading.ready = !r_valid || i_ready;
    assign w_take          = i_reading.valid && i_reading.ready;

    // Sign and magnitude of the 14-bit two's complement field.
    assign w_neg   = i_reading.raw_reading[15];
    assign w_field = i_reading.raw_reading[15:2];
    assign w_mag   = w_neg ? (~w_field + 14'd1) : w_field;

    // Tenths are 5*m/16; round the remainder half to even.
    assign w_prod  = {w_mag, 2'b00} + {2'b00, w_mag};
    assign w_trunc = w_prod[15:4];
    assign w_rem   = w_prod[3:0];
    assign w_up    = (w_rem > REM_HALF) || ((w_rem == REM_HALF) && w_trunc[0]);

    assign n_count = r_count + 16'd1;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_count <= '0;
        end else begin
            if (w_take) begin
                r_valid <= 1'b1;
                r_count <= n_count;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Payload register.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_data.negative <= w_neg;
            r_data.tenths   <= w_trunc + {11'd0, w_up};
            r_data.count    <= n_count;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// File: rtl/core/tr2a_divide.sv
`default_nettype none

module tr2a_divide
    import tr2a_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire t_rounded   i_data,
    output logic            o_valid,
    input  wire logic       i_ready,
    output t_quotients      o_data
);

    logic              r_valid;
    t_quotients        r_data;
    logic              w_take;
    logic [PROD_W-1:0] w_p10;
    logic [PROD_W-1:0] w_p100;
    logic [PROD_W-1:0] w_p1000;

    assign o_ready = !r_valid || i_ready;
    assign w_take  = i_valid && o_ready;

    // Three independent reciprocal multiplies give t/10, t/100 and t/1000.
    assign w_p10   = PROD_W'(i_data.tenths) * PROD_W'(RECIP_10);
    assign w_p100  = PROD_W'(i_data.tenths) * PROD_W'(RECIP_100);
    assign w_p1000 = PROD_W'(i_data.tenths) * PROD_W'(RECIP_1000);

    // Control register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Payload register.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_data.negative <= i_data.negative;
            r_data.tenths   <= i_data.tenths;
            r_data.q_ten    <= w_p10[23:15];
            r_data.q_hun    <= w_p100[21:17];
            r_data.q_thou   <= w_p1000[21:20];
            r_data.count    <= i_data.count;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// File: rtl/core/tr2a_ascii.sv
`default_nettype none

module tr2a_ascii
    import tr2a_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire t_quotients   i_data,
    tr2a_out_if.source        o_report
);

    logic               r_valid;
    logic [5:0]         r_sign;
    logic [5:0]         r_hun;
    logic [5:0]         r_ten;
    logic [5:0]         r_unit;
    logic [5:0]         r_tenth;
    logic [CNT_W-1:0]   r_count;
    logic               w_take;
    logic [TENTH_W-1:0] w_d0;
    logic [8:0]         w_d1;
    logic [4:0]         w_d2;

    assign o_ready = !r_valid || o_report.ready;
    assign w_take  = i_valid && o_ready;

    // Each digit is a quotient less ten times the next one up.
    assign w_d0 = i_data.tenths - ({i_data.q_ten, 3'b000} + {2'b00, i_data.q_ten, 1'b0});
    assign w_d1 = i_data.q_ten - ({i_data.q_hun, 3'b000} + {3'b000, i_data.q_hun, 1'b0});
    assign w_d2 = i_data.q_hun - ({i_data.q_thou, 3'b000} + {2'b00, i_data.q_thou, 1'b0});

    // Control register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_valid <= 1'b1;
            end else if (o_report.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_sign  <= i_data.negative ? CHAR_MINUS : CHAR_PLUS;
            r_hun   <= to_ascii({2'b00, i_data.q_thou});
            r_ten   <= to_ascii(w_d2[3:0]);
            r_unit  <= to_ascii(w_d1[3:0]);
            r_tenth <= to_ascii(w_d0[3:0]);
            r_count <= i_data.count;
        end
    end

    assign o_report.valid         = r_valid;
    assign o_report.sign_char     = r_sign;
    assign o_report.hundreds_char = r_hun;
    assign o_report.tens_char     = r_ten;
    assign o_report.units_char    = r_unit;
    assign o_report.point_char    = CHAR_POINT;
    assign o_report.tenths_char   = r_tenth;
    assign o_report.count_high    = r_count[15:8];
    assign o_report.count_low     = r_count[7:0];

endmodule

`default_nettype wire

// File: test/tb_temp_reading_to_ascii_report_unit.sv
`timescale 1ns / 100ps

module tb_temp_reading_to_ascii_report_unit;
    import tr2a_pkg::*;

    localparam int RESET_CYCLES   = 10;
    localparam int PIPE_LATENCY   = 3;
    localparam int DRAIN_CYCLES   = PIPE_LATENCY + 8;
    localparam int LONG_HOLD      = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTED   = 20;
    localparam logic [3:0] HALF_REMAINDER = 4'd8;

    // One expected report, field for field as the output word carries it.
    typedef struct packed {
        logic [5:0] sign_char;
        logic [5:0] hundreds_char;
        logic [5:0] tens_char;
        logic [5:0] units_char;
        logic [5:0] point_char;
        logic [5:0] tenths_char;
        logic [7:0] count_high;
        logic [7:0] count_low;
    } t_report;

    logic i_clk;
    logic i_rst_n;

    tr2a_in_if  reading_if ();
    tr2a_out_if report_if ();

    temp_reading_to_ascii_report_unit u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_reading (reading_if),
        .o_report  (report_if)
    );

    t_report     pending_reports [$];
    logic [15:0] sample_count_model;
    int          readings_sent;
    int          reports_checked;
    int          mismatch_count;
    int          idle_cycles;
    int          long_hold_req;
    int          rx_stall_left;
    bit          tx_idle_on;
    bit          rx_idle_on;

    // Free-running clock, 12 ns period.
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Expected report for one reading, given the sample count after increment.
    function automatic t_report predict_report(input logic [15:0] raw,
                                               input logic [15:0] count);
        logic [13:0] field;
        logic [14:0] mag;
        logic [17:0] prod;
        logic [11:0] tenths;
        t_report     rpt;
        field = raw[15:2];
        mag   = raw[15] ? 15'd16384 - {1'b0, field} : {1'b0, field};
        prod  = mag * 18'd5;
        tenths = prod[15:4];
        // Round half to even on the sixteenths remainder.
        if (prod[3:0] > HALF_REMAINDER || (prod[3:0] == HALF_REMAINDER && tenths[0])) begin
            tenths = tenths + 12'd1;
        end
        rpt.sign_char     = raw[15] ? CHAR_MINUS : CHAR_PLUS;
        rpt.hundreds_char = CHAR_ZERO + 6'((tenths / 1000) % 10);
        rpt.tens_char     = CHAR_ZERO + 6'((tenths / 100) % 10);
        rpt.units_char    = CHAR_ZERO + 6'((tenths / 10) % 10);
        rpt.point_char    = CHAR_POINT;
        rpt.tenths_char   = CHAR_ZERO + 6'(tenths % 10);
        rpt.count_high    = count[15:8];
        rpt.count_low     = count[7:0];
        return rpt;
    endfunction

    // Random reading, weighted toward zero, the extremes and exact halves.
    function automatic logic [15:0] pick_reading();
        logic [13:0] field;
        logic [1:0]  low_bits;
        low_bits = 2'($urandom_range(0, 3));
        case ($urandom_range(0, 5))
            0, 1: begin
                return 16'($urandom_range(0, 65535));
            end
            2: begin
                field = 14'($urandom_range(0, 15));
                if ($urandom_range(0, 1) == 1) begin
                    field = -field;
                end
            end
            3: begin
                if ($urandom_range(0, 1) == 1) begin
                    field = 14'h1FFF - 14'($urandom_range(0, 15));
                end else begin
                    field = 14'h2000 + 14'($urandom_range(0, 15));
                end
            end
            4: begin
                field = 14'(($urandom_range(0, 511) << 4) | 8);
                if ($urandom_range(0, 1) == 1) begin
                    field = -field;
                end
            end
            default: begin
                field = 14'($urandom_range(0, 16383));
            end
        endcase
        return {field, low_bits};
    endfunction

    function automatic void check_field(input string label, input logic [7:0] expected,
                                        input logic [7:0] actual);
        if (actual !== expected) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTED) begin
                $display("%0t: %s mismatch: expected %0d, actual %0d",
                         $time, label, expected, actual);
            end
        end
    endfunction

    // Offer one reading, with an optional idle burst first, and record the
    // expected report once the word is taken.
    task automatic send_reading(input logic [15:0] raw);
        int gap;
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 16);
            reading_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        reading_if.valid       <= 1'b1;
        reading_if.raw_reading <= raw;
        do @(posedge i_clk); while (reading_if.ready !== 1'b1);
        sample_count_model = sample_count_model + 16'd1;
        pending_reports.push_back(predict_report(raw, sample_count_model));
        readings_sent++;
    endtask

    task automatic release_input();
        reading_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (pending_reports.size() != 0) @(posedge i_clk);
    endtask

    // Corner readings: zero, ignored low bits, both extremes, small negatives,
    // exact halves of both parities, a carry into the hundreds digit.
    task automatic test_directed_readings();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        send_reading(16'h0000);
        send_reading(16'h0001);
        send_reading(16'h0002);
        send_reading(16'h0003);
        send_reading(16'h7FFC);
        send_reading(16'h7FFF);
        send_reading(16'h8000);
        send_reading(16'h8003);
        send_reading(16'hFFFC);
        send_reading(16'hFFFF);
        send_reading(16'hFFF8);
        send_reading(16'h0020);
        send_reading(16'h0060);
        send_reading(16'hFFE0);
        send_reading(16'hFFA0);
        send_reading(16'h0014);
        send_reading(16'h002C);
        send_reading(16'h31FC);
        send_reading(16'h5555);
        send_reading(16'hAAAA);
        send_reading(16'h1234);
    endtask

    // Segments of random readings with idling switched on and off at random.
    task automatic test_random_readings();
        int seg;
        int n;
        for (seg = 0; seg < 13; seg++) begin
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            for (n = 0; n < 100; n++) begin
                send_reading(pick_reading());
            end
            if (seg % 4 == 3) begin
                release_input();
                wait_drained();
            end
        end
    endtask

    // The receiver stalls for a long time while readings keep coming, so the
    // stages fill and the input must stall.
    task automatic test_output_backpressure();
        int n;
        tx_idle_on    = 1'b0;
        rx_idle_on    = 1'b0;
        long_hold_req = LONG_HOLD;
        for (n = 0; n < 40; n++) begin
            send_reading(pick_reading());
        end
    endtask

    // The sender stops until every report is out, then resumes.
    task automatic test_sender_pause();
        int n;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        for (n = 0; n < 20; n++) begin
            send_reading(pick_reading());
        end
        release_input();
        wait_drained();
        for (n = 0; n < 20; n++) begin
            send_reading(pick_reading());
        end
    endtask

    // Back-to-back readings at full rate, without idling on either side.
    task automatic test_full_rate();
        int n;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        for (n = 0; n < 50; n++) begin
            send_reading(pick_reading());
        end
    endtask

    // Receiver: random stall bursts, plus a long hold when one is requested.
    always @(posedge i_clk) begin
        if (long_hold_req > 0) begin
            rx_stall_left = long_hold_req;
            long_hold_req = 0;
        end else if (rx_stall_left == 0 && rx_idle_on && $urandom_range(0, 7) == 0) begin
            rx_stall_left = $urandom_range(1, 16);
        end
        if (rx_stall_left > 0) begin
            report_if.ready <= 1'b0;
            rx_stall_left--;
        end else begin
            report_if.ready <= 1'b1;
        end
    end

    // Compare each accepted report with the oldest expected one.
    always @(posedge i_clk) begin : report_check
        t_report expected_rpt;
        if (i_rst_n === 1'b1 && report_if.valid === 1'b1 && report_if.ready === 1'b1) begin
            if (pending_reports.size() == 0) begin
                mismatch_count++;
                $display("%0t: report with none pending: expected nothing, actual count %0d",
                         $time, {report_if.count_high, report_if.count_low});
            end else begin
                expected_rpt = pending_reports.pop_front();
                check_field("sign_char", {2'b00, expected_rpt.sign_char},
                            {2'b00, report_if.sign_char});
                check_field("hundreds_char", {2'b00, expected_rpt.hundreds_char},
                            {2'b00, report_if.hundreds_char});
                check_field("tens_char", {2'b00, expected_rpt.tens_char},
                            {2'b00, report_if.tens_char});
                check_field("units_char", {2'b00, expected_rpt.units_char},
                            {2'b00, report_if.units_char});
                check_field("point_char", {2'b00, expected_rpt.point_char},
                            {2'b00, report_if.point_char});
                check_field("tenths_char", {2'b00, expected_rpt.tenths_char},
                            {2'b00, report_if.tenths_char});
                check_field("count_high", expected_rpt.count_high, report_if.count_high);
                check_field("count_low", expected_rpt.count_low, report_if.count_low);
                reports_checked++;
            end
        end
    end

    // Watchdog on cycles in which no word moves on either side.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if ((reading_if.valid === 1'b1 && reading_if.ready === 1'b1)
                || (report_if.valid === 1'b1 && report_if.ready === 1'b1)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired with %0d reports pending",
                         $time, pending_reports.size());
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n                = 1'b0;
        reading_if.valid       = 1'b0;
        reading_if.raw_reading = 16'h0000;
        report_if.ready        = 1'b0;
        sample_count_model     = 16'd0;
        readings_sent          = 0;
        reports_checked        = 0;
        mismatch_count         = 0;
        idle_cycles            = 0;
        long_hold_req          = 0;
        rx_stall_left          = 0;
        tx_idle_on             = 1'b1;
        rx_idle_on             = 1'b1;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_readings();
        test_random_readings();
        test_output_backpressure();
        test_sender_pause();
        test_full_rate();

        release_input();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("summary: %0d readings sent, %0d reports checked, %0d mismatches",
                 readings_sent, reports_checked, mismatch_count);
        $display("summary: corners, rounding ties, long output stall, sender pause, full rate");
        if (mismatch_count == 0 && pending_reports.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/tr2a_pkg.sv
rtl/core/tr2a_in_if.sv
rtl/core/tr2a_out_if.sv
rtl/core/tr2a_round.sv
rtl/core/tr2a_divide.sv
rtl/core/tr2a_ascii.sv
rtl/core/temp_reading_to_ascii_report_unit.sv
test/tb_temp_reading_to_ascii_report_unit.sv
